### src/htd_pkg.sv
// Shared types and constants for the Huffman tree decoder.
// No dependencies; used by htd_front, htd_back and huffman_tree_decoder.
package htd_pkg;

    localparam int NODE_COUNT_DEF = 256;
    localparam int TABLE_SLOTS    = 256;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_BIT  = 1'b1;

    localparam logic [7:0] ROOT_NODE = 8'd0;

    typedef struct packed {
        logic       kind;
        logic [7:0] node_index;
        logic       left_is_leaf;
        logic [7:0] left_value;
        logic       right_is_leaf;
        logic [7:0] right_value;
        logic       code_bit;
    } t_in_item;

    typedef struct packed {
        logic [7:0] symbol;
        logic       error;
    } t_out_item;

    typedef struct packed {
        logic       left_is_leaf;
        logic [7:0] left_value;
        logic       right_is_leaf;
        logic [7:0] right_value;
    } t_node;

    // classified request between front and back
    typedef struct packed {
        logic       is_bit;
        logic [7:0] node_index;
        t_node      node;
        logic       code_bit;
    } t_cmd;

    typedef enum logic {
        BK_DISPATCH,
        BK_RESOLVE
    } t_back_state;

endpackage

### src/huffman_tree_decoder.sv
// Top level of the Huffman tree decoder: front queue, back walker, config register.
// Depends on htd_pkg, htd_front and htd_back.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------
//  input    | i_in_valid / o_in_ready  | i_in_item  (t_in_item)
//  output   | o_out_valid / i_out_ready| o_out_item (t_out_item)
//  config   | i_cfg_valid / o_cfg_ready| i_cfg_data (single_leaf_tree)
//
// A code bit passes the back end as a synchronous node table read at the current
// node, then the child select that sets the next node; a load is a table write.
// A two-entry queue parts input from the walker and an output register parts the
// walker from the output; a held result stalls the walker, then the input once
// the queue fills. Synchronous reset empties the queue, drops any pending result
// and returns the walk to the root; the node table is not cleared.
module huffman_tree_decoder #(
    parameter int NODE_COUNT = htd_pkg::NODE_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  htd_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output htd_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);
    import htd_pkg::*;

    logic r_single_leaf_tree;
    logic q_valid;
    logic q_ready;
    t_cmd q_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_single_leaf_tree <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_single_leaf_tree <= i_cfg_data;
        end
    end

    htd_front #(
        .NODE_COUNT(NODE_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_q_valid  (q_valid),
        .i_q_ready  (q_ready),
        .o_q_cmd    (q_cmd)
    );

    htd_back #(
        .NODE_COUNT(NODE_COUNT)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_single_leaf_tree (r_single_leaf_tree),
        .i_q_valid          (q_valid),
        .o_q_ready          (q_ready),
        .i_q_cmd            (q_cmd),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_item         (o_out_item)
    );

endmodule

### src/htd_front.sv
// Front end: accepts input requests, classifies them and queues them, dropping loads aimed past the table.
// Depends on htd_pkg.
module htd_front #(
    parameter int NODE_COUNT = htd_pkg::NODE_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  htd_pkg::t_in_item i_in_item,
    output logic              o_q_valid,
    input  logic              i_q_ready,
    output htd_pkg::t_cmd     o_q_cmd
);
    import htd_pkg::*;

    localparam int QDEPTH = 2;

    t_cmd       r_queue [QDEPTH];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    t_cmd cmd;
    logic accept;
    logic push;
    logic pop;
    logic load_ok;

    assign o_in_ready = (r_count != 2'(QDEPTH));
    assign accept     = i_in_valid && o_in_ready;
    assign load_ok    = (32'(i_in_item.node_index) < NODE_COUNT);

    always_comb begin
        cmd.is_bit             = (i_in_item.kind == KIND_BIT);
        cmd.node_index         = i_in_item.node_index;
        cmd.node.left_is_leaf  = i_in_item.left_is_leaf;
        cmd.node.left_value    = i_in_item.left_value;
        cmd.node.right_is_leaf = i_in_item.right_is_leaf;
        cmd.node.right_value   = i_in_item.right_value;
        cmd.code_bit           = i_in_item.code_bit;
    end

    // drop loads aimed past the table
    assign push = accept && (cmd.is_bit || load_ok);
    assign pop  = o_q_valid && i_q_ready;

    assign o_q_valid = (r_count != 2'd0);
    assign o_q_cmd   = r_queue[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= cmd;
        end
    end

endmodule

### src/htd_back.sv
// Back end: node table memory, tree walk and the output register.
// Depends on htd_pkg.
module htd_back #(
    parameter int NODE_COUNT = htd_pkg::NODE_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_single_leaf_tree,
    input  logic               i_q_valid,
    output logic               o_q_ready,
    input  htd_pkg::t_cmd      i_q_cmd,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output htd_pkg::t_out_item o_out_item
);
    import htd_pkg::*;

    localparam int DEPTH  = (NODE_COUNT < TABLE_SLOTS) ? NODE_COUNT : TABLE_SLOTS;
    localparam int ADDR_W = $clog2(DEPTH);

    t_node       r_node_mem [DEPTH];
    t_node       r_rd_data;
    logic        r_rd_ok;
    logic        r_bit;
    logic [7:0]  r_cur, n_cur;
    t_back_state r_state, n_state;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic       mem_we;
    logic       rd_en;
    logic       resolve;
    logic       slot_free;
    logic       cur_ok;
    t_node      entry;
    logic       child_leaf;
    logic [7:0] child_value;

    assign slot_free = !r_out_valid || i_out_ready;
    assign cur_ok    = (32'(r_cur) < NODE_COUNT);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_DISPATCH: begin
                if (i_q_valid && i_q_cmd.is_bit) n_state = BK_RESOLVE;
            end
            BK_RESOLVE: begin
                if (slot_free) n_state = BK_DISPATCH;
            end
            default: n_state = BK_DISPATCH;
        endcase
    end

    // state outputs
    always_comb begin
        o_q_ready = 1'b0;
        mem_we    = 1'b0;
        rd_en     = 1'b0;
        resolve   = 1'b0;
        case (r_state)
            BK_DISPATCH: begin
                o_q_ready = 1'b1;
                mem_we    = i_q_valid && !i_q_cmd.is_bit;
                rd_en     = i_q_valid && i_q_cmd.is_bit;
            end
            BK_RESOLVE: begin
                resolve = slot_free;
            end
            default: ;
        endcase
    end

    // nodes past the table read as all zero: both children lead back to the root
    assign entry       = r_rd_ok ? r_rd_data : '0;
    assign child_leaf  = r_bit ? entry.right_is_leaf : entry.left_is_leaf;
    assign child_value = r_bit ? entry.right_value   : entry.left_value;

    always_comb begin
        n_cur       = r_cur;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        if (resolve) begin
            if (i_single_leaf_tree) begin
                n_cur        = ROOT_NODE;
                n_out.symbol = '0;
                n_out.error  = 1'b1;
                n_out_valid  = 1'b1;
            end else if (child_leaf) begin
                n_cur        = ROOT_NODE;
                n_out.symbol = child_value;
                n_out.error  = 1'b0;
                n_out_valid  = 1'b1;
            end else begin
                n_cur = child_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_DISPATCH;
            r_cur       <= ROOT_NODE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (rd_en) begin
            r_bit   <= i_q_cmd.code_bit;
            r_rd_ok <= cur_ok;
        end
    end

    // node table: one write or one read per cycle, read data registered
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_node_mem[i_q_cmd.node_index[ADDR_W-1:0]] <= i_q_cmd.node;
        end
        if (rd_en) begin
            r_rd_data <= r_node_mem[r_cur[ADDR_W-1:0]];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_one_port_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && rd_en))
        else $error("node table written and read in the same cycle");

    a_read_then_resolve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |=> (r_state == BK_RESOLVE))
        else $error("table read not followed by resolve");

    a_out_from_resolve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == BK_RESOLVE))
        else $error("result appeared outside resolve");

    a_error_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error) |-> (r_out.symbol == 8'd0))
        else $error("error result carries a symbol");

    a_result_to_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (resolve && (i_single_leaf_tree || child_leaf)) |=> (r_cur == ROOT_NODE))
        else $error("walk did not return to root after a result");

endmodule
